/* rtl/spmf_pkg.sv */
package spmf_pkg;

    // sizing of the queue set
    localparam int NUM_LEVELS = 8;
    localparam int CAPACITY   = 64;

    // derived widths
    localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int DEPTH   = NUM_LEVELS * CAPACITY;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int EFF_W   = 5;

    // fixed field widths
    localparam int PRIO_W  = 3;
    localparam int ELEM_W  = 32;
    localparam int ACT_W   = 4;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [PRIO_W-1:0] priority_req;
        logic [ELEM_W-1:0] element_in;
    } t_item_in;

    typedef struct packed {
        logic [ELEM_W-1:0] element_out;
        logic              element_valid;
        logic              rejected;
        logic              is_full;
        logic              is_empty;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REPLY
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic decide;
    } t_ctrl_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic result_ready;
    } t_ctrl_sts;

endpackage

/* rtl/spmf_ram.sv */
module spmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/spmf_ctrl.sv */
module spmf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  spmf_pkg::t_ctrl_sts   i_sts,
    output spmf_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_busy,
    output logic                  o_strobe
);

    spmf_pkg::t_state r_state;
    spmf_pkg::t_state n_state;
    logic             accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spmf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command decode
    always_comb begin
        o_busy     = 1'b0;
        o_strobe   = 1'b0;
        o_cmd      = '0;
        n_state    = r_state;
        accept     = 1'b0;
        case (r_state)
            spmf_pkg::ST_IDLE: begin
                accept = i_start;
                if (accept) begin
                    n_state = spmf_pkg::ST_DECIDE;
                end
            end
            spmf_pkg::ST_DECIDE: begin
                o_busy       = 1'b1;
                o_cmd.decide = 1'b1;
                n_state      = spmf_pkg::ST_REPLY;
            end
            spmf_pkg::ST_REPLY: begin
                // result shown this cycle, next item may already enter
                o_strobe = i_sts.result_ready;
                accept   = i_start;
                n_state  = accept ? spmf_pkg::ST_DECIDE : spmf_pkg::ST_IDLE;
            end
            default: begin
                n_state = spmf_pkg::ST_IDLE;
            end
        endcase
        o_cmd.load = accept;
    end

    // a decision is always followed by its reply
    a_decide_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spmf_pkg::ST_DECIDE |=> r_state == spmf_pkg::ST_REPLY)
        else $error("decision not followed by reply");

    // items are only taken while not busy
    a_load_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("item loaded while busy");

    // strobe only in the reply cycle
    a_strobe_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(o_cmd.decide))
        else $error("strobe without prior decision");

endmodule

/* rtl/spmf_datapath.sv */
module spmf_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spmf_pkg::t_ctrl_cmd               i_cmd,
    output spmf_pkg::t_ctrl_sts               o_sts,
    input  spmf_pkg::t_item_in                i_item,
    input  logic                              i_cfg_we,
    input  logic [spmf_pkg::ACT_W-1:0]        i_cfg_data,
    output spmf_pkg::t_result                 o_res
);

    // latched item
    logic                              r_mode;
    logic [spmf_pkg::PRIO_W-1:0]       r_prio;
    logic [spmf_pkg::ELEM_W-1:0]       r_elem;

    // queue bookkeeping
    logic [spmf_pkg::PTR_W-1:0]        r_head  [spmf_pkg::NUM_LEVELS];
    logic [spmf_pkg::PTR_W-1:0]        r_tail  [spmf_pkg::NUM_LEVELS];
    logic [spmf_pkg::CNT_W-1:0]        r_count [spmf_pkg::NUM_LEVELS];
    logic [spmf_pkg::CNT_W-1:0]        n_count [spmf_pkg::NUM_LEVELS];
    logic [spmf_pkg::CNT_W-1:0]        r_total;
    logic [spmf_pkg::CNT_W-1:0]        n_total;
    logic [spmf_pkg::ACT_W-1:0]        r_active;

    // result flags
    logic                              r_valid;
    logic                              r_rej;
    logic                              r_full;
    logic                              r_empty;
    logic                              r_done;

    logic [spmf_pkg::EFF_W-1:0]        eff_n;
    logic [spmf_pkg::LVL_W-1:0]        ins_lvl;
    logic [spmf_pkg::LVL_W-1:0]        sel_lvl;
    logic [spmf_pkg::LVL_W-1:0]        op_lvl;
    logic                              found;
    logic                              ins_ok;
    logic                              do_ins;
    logic                              do_rem;
    logic                              empty_after;
    logic [spmf_pkg::PTR_W-1:0]        op_ptr;
    logic [spmf_pkg::ADDR_W-1:0]       ram_addr;
    logic [spmf_pkg::ELEM_W-1:0]       ram_rdata;

    // effective level count: zero acts as one, clipped to the level count
    always_comb begin
        logic [spmf_pkg::EFF_W-1:0] a;
        a = spmf_pkg::EFF_W'(r_active);
        if (a == '0) begin
            eff_n = spmf_pkg::EFF_W'(1);
        end else if (a > spmf_pkg::EFF_W'(spmf_pkg::NUM_LEVELS)) begin
            eff_n = spmf_pkg::EFF_W'(spmf_pkg::NUM_LEVELS);
        end else begin
            eff_n = a;
        end
    end

    // priority encoder over the active non-empty levels
    always_comb begin
        sel_lvl = '0;
        found   = 1'b0;
        for (int i = spmf_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
            if ((spmf_pkg::EFF_W'(i) < eff_n) && (r_count[i] != '0)) begin
                sel_lvl = spmf_pkg::LVL_W'(i);
                found   = 1'b1;
            end
        end
    end

    // insert check and operation select
    assign ins_lvl = spmf_pkg::LVL_W'(r_prio);
    assign ins_ok  = (r_total < spmf_pkg::CNT_W'(spmf_pkg::CAPACITY))
                  && (spmf_pkg::EFF_W'(r_prio) < eff_n);
    assign do_ins  = i_cmd.decide && (r_mode == spmf_pkg::MODE_INSERT) && ins_ok;
    assign do_rem  = i_cmd.decide && (r_mode == spmf_pkg::MODE_REMOVE) && found;
    assign op_lvl  = (r_mode == spmf_pkg::MODE_INSERT) ? ins_lvl : sel_lvl;
    assign op_ptr  = (r_mode == spmf_pkg::MODE_INSERT) ? r_tail[op_lvl] : r_head[op_lvl];
    assign ram_addr = spmf_pkg::ADDR_W'(op_lvl) * spmf_pkg::ADDR_W'(spmf_pkg::CAPACITY)
                    + spmf_pkg::ADDR_W'(op_ptr);

    // counts after this step
    always_comb begin
        for (int i = 0; i < spmf_pkg::NUM_LEVELS; i++) begin
            n_count[i] = r_count[i];
        end
        n_total = r_total;
        if (do_ins) begin
            n_count[op_lvl] = r_count[op_lvl] + 1'b1;
            n_total         = r_total + 1'b1;
        end else if (do_rem) begin
            n_count[op_lvl] = r_count[op_lvl] - 1'b1;
            n_total         = r_total - 1'b1;
        end
    end

    // emptiness of the active levels after this step
    always_comb begin
        empty_after = 1'b1;
        for (int i = 0; i < spmf_pkg::NUM_LEVELS; i++) begin
            if ((spmf_pkg::EFF_W'(i) < eff_n) && (n_count[i] != '0)) begin
                empty_after = 1'b0;
            end
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_item.mode;
            r_prio <= i_item.priority_req;
            r_elem <= i_item.element_in;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= spmf_pkg::ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_data;
        end
    end

    // ring pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < spmf_pkg::NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_total <= '0;
        end else begin
            for (int i = 0; i < spmf_pkg::NUM_LEVELS; i++) begin
                r_count[i] <= n_count[i];
            end
            r_total <= n_total;
            if (do_ins) begin
                r_tail[op_lvl] <= (op_ptr == spmf_pkg::PTR_W'(spmf_pkg::CAPACITY - 1))
                                ? '0 : op_ptr + 1'b1;
            end
            if (do_rem) begin
                r_head[op_lvl] <= (op_ptr == spmf_pkg::PTR_W'(spmf_pkg::CAPACITY - 1))
                                ? '0 : op_ptr + 1'b1;
            end
        end
    end

    // result flags, shown in the cycle after the decision
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rej   <= 1'b0;
            r_full  <= 1'b0;
            r_empty <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.decide;
            if (i_cmd.decide) begin
                r_valid <= do_rem;
                r_rej   <= !(do_ins || do_rem);
                r_full  <= (n_total == spmf_pkg::CNT_W'(spmf_pkg::CAPACITY));
                r_empty <= empty_after;
            end
        end
    end

    // element storage
    spmf_ram #(
        .WIDTH (spmf_pkg::ELEM_W),
        .DEPTH (spmf_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_ins),
        .i_waddr (ram_addr),
        .i_wdata (r_elem),
        .i_re    (do_rem),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // result assembly
    assign o_res.element_out   = r_valid ? ram_rdata : '0;
    assign o_res.element_valid = r_valid;
    assign o_res.rejected      = r_rej;
    assign o_res.is_full       = r_full;
    assign o_res.is_empty      = r_empty;
    assign o_sts.result_ready  = r_done;

    // shared total never exceeds capacity
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= spmf_pkg::CNT_W'(spmf_pkg::CAPACITY))
        else $error("total count above capacity");

    // a popped item is never also rejected
    a_valid_not_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_rej)
        else $error("valid and rejected together");

    // a pop lowers the total by one
    a_pop_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_rem |=> r_total == $past(r_total) - 1'b1)
        else $error("pop did not lower total");

endmodule

/* rtl/strict_priority_multi_fifo.sv */
// the item is captured when start is accepted and decided in the decide state; the
// result is shown in the reply state, the element via the registered memory read port;
// the next start is already taken in the reply cycle, while the result is shown
// reset: synchronous active low; all levels empty, active levels back to eight,
// element memory contents undefined until written
// the receiver cannot stall: each result is shown for one cycle only
module strict_priority_multi_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  spmf_pkg::t_item_in         i_item,
    output logic                       o_res_strobe,
    output spmf_pkg::t_result          o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [spmf_pkg::ACT_W-1:0] i_cfg_data
);

    spmf_pkg::t_ctrl_cmd cmd;
    spmf_pkg::t_ctrl_sts sts;

    // sequencer
    spmf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_res_strobe)
    );

    // queue state and storage
    spmf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_res)
    );

    // configuration taken outside the decision cycle
    assign o_cfg_ready = !busy;

endmodule
